>>> design/svr_pkg.sv
// svr_pkg: shared types, constants and character tables of the secret value redactor.
// Holds the marker and replacement texts, the beat and stage-item types.
// No dependencies; every other design file imports it.
package svr_pkg;

  // Marker stages and counters
  localparam int NumMarkers  = 4;
  localparam int CountBits   = 16;
  localparam int NumKinds    = 4;   // kinds that own a hit counter output
  localparam int KindIdxW    = 2;
  localparam int SlotIdxW    = 3;
  localparam int MaxMarkLen  = 11;
  localparam int ProgW       = 4;   // holds 0..MaxMarkLen
  localparam int HitsW       = 16;

  // Replacement text
  localparam int ReplLen = 10;
  localparam int PosW    = 4;       // beat position, 0..ReplLen+1

  // Queue between front and back (power of two depth)
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;

  localparam logic [MaxMarkLen*8-1:0] MarkToken      = "token=";
  localparam logic [MaxMarkLen*8-1:0] MarkCookie     = "cookie=";
  localparam logic [MaxMarkLen*8-1:0] MarkSignedUrl  = {"signed_", "url="};
  localparam logic [MaxMarkLen*8-1:0] MarkCredential = "credential=";
  localparam logic [ReplLen*8-1:0]    ReplText       = "<redacted>";

  // What a stage hands on for one payload byte
  typedef enum logic [1:0] {
    BODY_NONE,   // byte was dropped
    BODY_BYTE,   // byte passes
    BODY_RED     // byte passes, followed by the replacement text
  } body_e;

  typedef struct packed {
    body_e                               body;
    logic [7:0]                          data;
    logic                                fin;   // final payload byte
    logic                                drop;  // some stage still inside a value
    logic [NumKinds-1:0][CountBits-1:0]  hits;  // filled on the final byte only
  } pkt_t;

  // One output beat
  typedef struct packed {
    logic [7:0]                      data;
    logic                            run_end;
    logic                            rend;
    logic [NumKinds-1:0][HitsW-1:0]  hits;
  } beat_t;

  function automatic logic [ProgW-1:0] marker_len(input logic [SlotIdxW-1:0] k);
    case (k)
      3'd0:    return ProgW'(6);
      3'd1:    return ProgW'(7);
      3'd2:    return ProgW'(11);
      3'd3:    return ProgW'(11);
      default: return '0;
    endcase
  endfunction

  function automatic logic [MaxMarkLen*8-1:0] marker_text(input logic [SlotIdxW-1:0] k);
    case (k)
      3'd0:    return MarkToken;
      3'd1:    return MarkCookie;
      3'd2:    return MarkSignedUrl;
      3'd3:    return MarkCredential;
      default: return '0;
    endcase
  endfunction

  // Character p of marker k (texts are right-aligned, first char highest)
  function automatic logic [7:0] marker_char(input logic [SlotIdxW-1:0] k,
                                             input logic [ProgW-1:0] p);
    logic [ProgW-1:0]          len;
    logic [ProgW-1:0]          sel;
    logic [MaxMarkLen*8-1:0]   txt;
    len = marker_len(k);
    txt = marker_text(k);
    sel = len - p - 1'b1;
    if (p >= len) return 8'h00;
    return txt[{sel, 3'b000} +: 8];
  endfunction

  // Character j of the replacement text
  function automatic logic [7:0] repl_char(input logic [PosW-1:0] j);
    logic [PosW-1:0] sel;
    sel = PosW'(ReplLen - 1) - j;
    if (j >= PosW'(ReplLen)) return 8'h00;
    return ReplText[{sel, 3'b000} +: 8];
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09) || (c == 8'h26);
  endfunction

endpackage

>>> design/secret_value_redactor.sv
// secret_value_redactor: top level of the streaming secret redactor.
// Uses svr_pkg, svr_stage, svr_fifo and svr_back.
//
// Input channel (s_axis): one payload byte per beat, tlast on the final byte.
// Output channel (m_axis): one redacted byte per beat; tuser marks the last beat
// caused by an input byte, tlast the final byte of the redacted payload, which
// also carries the four per-kind hit counts (zero on all other beats).
// Four marker stages (token, cookie, signed url, credential) form a
// registered pipeline; a four-entry queue decouples it from the output
// sequencer, which expands a completed marker into "<redacted>".
// Throughput: one input byte per cycle while s_axis_tready is high; a byte that
// completes a marker is expanded by the sequencer into itself and "<redacted>".
// A byte whose result is fully dropped still passes through the sequencer. The
// input beat passes three more stage registers, the queue and the output
// register before its first output beat is valid. While a value is being
// dropped the last produced byte is held until a byte no stage drops or the
// end of the payload. Reset clears scan state, counters, the queue and the held
// byte. When m_axis_tready is low the output register holds, the queue and
// then the stage registers fill, and then s_axis_tready drops; nothing is lost.
module secret_value_redactor import svr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // payload_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [23:8] token_hits, [39:24] cookie_hits,
  // [55:40] signed url hits, [71:56] credential_hits
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,   // redacted_end
  output logic [0:0]  m_axis_tuser    // [0] run_end
);

  logic  st_valid [NumMarkers+1];
  logic  st_ready [NumMarkers+1];
  pkt_t  st_pkt   [NumMarkers+1];
  logic  q_valid, q_ready;
  pkt_t  q_pkt;
  beat_t beat;

  // Input beat becomes a stage item
  assign st_valid[0]      = s_axis_tvalid;
  assign s_axis_tready    = st_ready[0];
  assign st_pkt[0].body   = BODY_BYTE;
  assign st_pkt[0].data   = s_axis_tdata;
  assign st_pkt[0].fin    = s_axis_tlast;
  assign st_pkt[0].drop   = 1'b0;
  assign st_pkt[0].hits   = '0;

  // Marker pipeline
  for (genvar k = 0; k < NumMarkers; k++) begin : g_stage
    svr_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_idx_i (SlotIdxW'(k)),
      .in_valid_i  (st_valid[k]),
      .in_ready_o  (st_ready[k]),
      .in_pkt_i    (st_pkt[k]),
      .out_valid_o (st_valid[k+1]),
      .out_ready_i (st_ready[k+1]),
      .out_pkt_o   (st_pkt[k+1])
    );
  end

  // Queue between front and back
  svr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (st_valid[NumMarkers]),
    .push_ready_o (st_ready[NumMarkers]),
    .push_pkt_i   (st_pkt[NumMarkers]),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_pkt_o    (q_pkt)
  );

  // Output sequencer
  svr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .pop_pkt_i   (q_pkt),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_beat_o  (beat)
  );

  // Output packing
  assign m_axis_tdata    = {beat.hits[3], beat.hits[2], beat.hits[1], beat.hits[0], beat.data};
  assign m_axis_tlast    = beat.rend;
  assign m_axis_tuser[0] = beat.run_end;

endmodule

>>> design/svr_stage.sv
// svr_stage: one marker pass of the front pipeline, with its own scan state and counter.
// Takes one stage item per beat and registers the result for the next stage.
// Depends on svr_pkg.
module svr_stage import svr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SlotIdxW-1:0] stage_idx_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pkt_t                in_pkt_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pkt_t                out_pkt_o
);

  logic [ProgW-1:0]     prog_q, prog_d;
  logic                 inside_q, inside_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 out_valid_q;
  pkt_t                 out_pkt_q, pkt_d;
  logic [ProgW-1:0]     len;
  logic [7:0]           c;
  logic                 scan;
  logic                 accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_pkt_o   = out_pkt_q;

  // Scan one byte against this stage's marker
  always_comb begin
    len      = marker_len(stage_idx_i);
    c        = in_pkt_i.data;
    prog_d   = prog_q;
    inside_d = inside_q;
    count_d  = count_q;
    pkt_d    = in_pkt_i;
    scan     = 1'b0;
    if (len != '0 && in_pkt_i.body != BODY_NONE) begin
      scan = 1'b1;
      // inside a value: only a delimiter ends it, everything else is dropped
      if (inside_q) begin
        if (is_delim(c)) begin
          inside_d = 1'b0;
          prog_d   = '0;
        end else begin
          scan = 1'b0;
        end
      end
      if (scan) begin
        if (prog_d < len && c == marker_char(stage_idx_i, prog_d)) begin
          prog_d = prog_d + 1'b1;
        end else begin
          prog_d = (c == marker_char(stage_idx_i, '0)) ? ProgW'(1) : '0;
        end
        if (prog_d >= len) begin
          prog_d     = '0;
          inside_d   = 1'b1;
          pkt_d.body = BODY_RED;
          if (count_q != '1) begin
            count_d = count_q + 1'b1;
          end
        end
        // the replacement text that follows ends on a char no marker starts with
        if (in_pkt_i.body == BODY_RED) begin
          prog_d = '0;
        end
      end else begin
        pkt_d.body = BODY_NONE;
      end
    end
    pkt_d.drop = in_pkt_i.drop | inside_d;
    // end of payload: report the count and start over
    if (in_pkt_i.fin) begin
      if (stage_idx_i < SlotIdxW'(NumKinds)) begin
        pkt_d.hits[stage_idx_i[KindIdxW-1:0]] = count_d;
      end
      prog_d   = '0;
      inside_d = 1'b0;
      count_d  = '0;
    end
  end

  // Stage state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q      <= '0;
      inside_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (accept) begin
      prog_q      <= prog_d;
      inside_q    <= inside_d;
      count_q     <= count_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_pkt_q <= pkt_d;
    end
  end

  // Entering a value always restarts the marker scan
  a_inside_no_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q |-> prog_q == '0)
    else $error("svr_stage: progress kept while inside a value");

  // A completed marker never stays recorded as progress
  a_prog_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prog_q == '0) || (prog_q < marker_len(stage_idx_i)))
    else $error("svr_stage: match progress reached marker length");

endmodule

>>> design/svr_fifo.sv
// svr_fifo: short queue of stage items between the marker pipeline and the output sequencer.
// Register-based, one push (while not full) and one pop (while not empty) per cycle.
// Depends on svr_pkg.
module svr_fifo import svr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  pkt_t push_pkt_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output pkt_t pop_pkt_o
);

  pkt_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != (FifoPtrW + 1)'(FifoDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_pkt_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_pkt_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FifoPtrW + 1)'(FifoDepth))
    else $error("svr_fifo: fill level beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != (FifoPtrW + 1)'(FifoDepth)) |->
      (wr_q - rd_q) == cnt_q[FifoPtrW-1:0])
    else $error("svr_fifo: pointers disagree with fill level");

endmodule

>>> design/svr_back.sv
// svr_back: output sequencer; expands stage items into output beats.
// Keeps the held-back byte, inserts the replacement text and drives the output register.
// Depends on svr_pkg.
module svr_back import svr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  pop_valid_i,
  output logic  pop_ready_o,
  input  pkt_t  pop_pkt_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output beat_t out_beat_o
);

  logic [PosW-1:0] pos_q;
  logic            pend_valid_q;
  logic [7:0]      pend_byte_q;
  logic            out_valid_q;
  beat_t           out_beat_q;

  logic [PosW-1:0] nb, total, emit, idx;
  logic            hold, out_free, fire, last_beat, rend;
  logic [7:0]      beat_byte, tail_byte;

  // Beat count for the current item
  always_comb begin
    case (pop_pkt_i.body)
      BODY_NONE: nb = '0;
      BODY_BYTE: nb = PosW'(1);
      BODY_RED:  nb = PosW'(ReplLen + 1);
      default:   nb = '0;
    endcase
    total = nb + PosW'(pend_valid_q);
    hold  = !pop_pkt_i.fin && pop_pkt_i.drop && total != '0;
    emit  = total - PosW'(hold);
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign fire      = pop_valid_i && (emit == '0 || out_free);
  assign last_beat = (emit == '0) || (pos_q == emit - 1'b1);
  assign rend      = pop_pkt_i.fin && last_beat;
  assign idx       = pos_q - PosW'(pend_valid_q);

  // Byte at the current position, and the byte held back at the end
  always_comb begin
    if (pend_valid_q && pos_q == '0) begin
      beat_byte = pend_byte_q;
    end else if (idx == '0) begin
      beat_byte = pop_pkt_i.data;
    end else begin
      beat_byte = repl_char(idx - 1'b1);
    end
    case (pop_pkt_i.body)
      BODY_NONE: tail_byte = pend_byte_q;
      BODY_BYTE: tail_byte = pop_pkt_i.data;
      BODY_RED:  tail_byte = repl_char(PosW'(ReplLen - 1));
      default:   tail_byte = pend_byte_q;
    endcase
  end

  assign pop_ready_o = fire && last_beat;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Sequencer position, hold register and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire && emit != '0) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        if (last_beat) begin
          pos_q        <= '0;
          pend_valid_q <= hold;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (fire && last_beat && hold) begin
      pend_byte_q <= tail_byte;
    end
    if (fire && emit != '0) begin
      out_beat_q.data    <= beat_byte;
      out_beat_q.run_end <= last_beat;
      out_beat_q.rend    <= rend;
      for (int k = 0; k < NumKinds; k++) begin
        out_beat_q.hits[k] <= rend ? HitsW'(pop_pkt_i.hits[k]) : '0;
      end
    end
  end

  a_fin_clears_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_i && pop_ready_o && pop_pkt_i.fin) |=> !pend_valid_q)
    else $error("svr_back: byte still held after end of payload");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(ReplLen + 1))
    else $error("svr_back: beat position out of range");

endmodule
